// ----- src/whitened_k_nearest_selector_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the whitened k-nearest selector
// Concurrent checks on clk, disabled while rst is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef WHITENED_K_NEAREST_SELECTOR_CORE_ASSERT_SVH
`define WHITENED_K_NEAREST_SELECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WKN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("whitened_k_nearest_selector_core: check failed");
// next-cycle implication
`define WKN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("whitened_k_nearest_selector_core: check failed");
`else
`define WKN_ASSERT_NOW(lbl, ante, cons)
`define WKN_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/wkn_pkg.sv -----
// ----------------------------------------------------------------------------
// wkn_pkg
// Shared widths, codes and control types of the whitened k-nearest selector.
// ----------------------------------------------------------------------------
package wkn_pkg;

  localparam int ID_W     = 16;
  localparam int DATA_W   = 16;
  localparam int DIST_W   = 48;
  localparam int KEEP_W   = 7;
  localparam int MAG_W    = DATA_W + 1;
  localparam int MUL_W    = 24;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int W_W      = 32;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd8;
  localparam logic [W_W:0]      ROUND_BIAS = 33'd128;

  localparam logic KIND_ELEM   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [2:0] {
    DOP_IDLE,
    DOP_LOAD,
    DOP_MUL_W,
    DOP_MUL_SQ,
    DOP_ACC,
    DOP_CLEAR
  } dist_op_t;

  typedef struct packed {
    dist_op_t op;
    logic     last;
  } dist_ctl_t;

endpackage

// ----- src/wkn_channels.sv -----
// ----------------------------------------------------------------------------
// wkn channels
// Valid/ready channel interfaces: candidate input, result output, config.
// ----------------------------------------------------------------------------
interface wkn_cand_if;
  import wkn_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [ID_W-1:0]          cand_id;
  logic signed [DATA_W-1:0] elem_value;
  logic signed [DATA_W-1:0] ref_mean;
  logic [DATA_W-1:0]        inv_std;
  logic                     last_elem;
  logic                     skip_cand;

  modport source (output valid, kind, cand_id, elem_value, ref_mean, inv_std,
                  last_elem, skip_cand, input ready);
  modport sink (input valid, kind, cand_id, elem_value, ref_mean, inv_std,
                last_elem, skip_cand, output ready);
endinterface

interface wkn_result_if;
  import wkn_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   out_id;
  logic [DIST_W-1:0] out_distance;
  logic              out_last;
  logic              out_empty;

  modport source (output valid, out_id, out_distance, out_last, out_empty,
                  input ready);
  modport sink (input valid, out_id, out_distance, out_last, out_empty,
                output ready);
endinterface

interface wkn_cfg_if;
  import wkn_pkg::*;
  logic              valid;
  logic              ready;
  logic [KEEP_W-1:0] keep_count;

  modport source (output valid, keep_count, input ready);
  modport sink (input valid, keep_count, output ready);
endinterface

// ----- src/whitened_k_nearest_selector_core.sv -----
// ----------------------------------------------------------------------------
// whitened_k_nearest_selector_core
// Streams candidate vector elements, accumulates squared whitened distance
// and keeps the keep_count nearest candidates; a finish item emits the set.
// ----------------------------------------------------------------------------
// Usage:
//   cand   : one element per transaction (kind 0) or a finish (kind 1).
//   result : one transaction per held candidate in slot order, out_last on the
//            final one; a finish on an empty set gives one out_empty result.
//   cfg    : writes keep_count; always ready, write only while idle.
// Sequencing:
//   A counted element runs through load, two passes through the single 24x24
//   multiplier and the accumulate. A final element that displaces the current
//   maximum then rescans the slot memory, one read per cycle. A finish emits
//   each result by a memory read, then an output register load, which waits
//   while the receiver holds ready low.
// Reset: held set emptied, accumulator cleared, keep_count back to 8.
// A stalled receiver keeps the result register full; the block waits and
// accepts no candidate item until the last result is loaded for output.
// ----------------------------------------------------------------------------
module whitened_k_nearest_selector_core #(
  parameter int K_MAX = 64
) (
  input  logic         clk,
  input  logic         rst,
  wkn_cand_if.sink     cand,
  wkn_result_if.source result,
  wkn_cfg_if.sink      cfg
);
  import wkn_pkg::*;

  localparam int HCW = $clog2(K_MAX + 1);
  localparam int SAW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW  = (HCW > KEEP_W) ? HCW : KEEP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_W,
    S_MUL_SQ,
    S_ACC,
    S_SCAN,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMPTY
  } state_t;

  state_t            state;
  logic [KEEP_W-1:0] keep_count;
  logic [HCW-1:0]    keep_eff;
  logic [CW-1:0]     kc_w;
  logic [HCW-1:0]    held_count;
  logic [SAW-1:0]    max_slot;
  logic [DIST_W-1:0] max_dist;
  logic [HCW-1:0]    idx;
  logic [HCW-1:0]    idx_inc;
  logic              pend;
  logic [SAW-1:0]    pend_slot;
  logic [SAW-1:0]    best_slot;
  logic [DIST_W-1:0] best_dist;
  logic [ID_W-1:0]   cur_id;
  logic              cur_last;

  logic [ID_W-1:0]   slot_ids   [K_MAX];
  logic [DIST_W-1:0] slot_dists [K_MAX];
  logic [ID_W-1:0]   rd_id;
  logic [DIST_W-1:0] rd_dist;
  logic              wr_en;
  logic [SAW-1:0]    wr_addr;

  logic              out_valid;
  logic [ID_W-1:0]   out_id;
  logic [DIST_W-1:0] out_distance;
  logic              out_last;
  logic              out_empty;

  dist_ctl_t         dctl;
  logic [DIST_W-1:0] dist_sum;
  logic              cand_take;
  logic              fill;
  logic              replace;
  logic              out_free;
  logic              out_load;

  wkn_dist_unit u_dist (
    .clk        (clk),
    .rst        (rst),
    .ctl        (dctl),
    .elem_value (cand.elem_value),
    .ref_mean   (cand.ref_mean),
    .inv_std    (cand.inv_std),
    .dist_sum   (dist_sum)
  );

  // zero acts as one, anything above K_MAX as K_MAX
  always_comb begin
    kc_w = CW'(keep_count);
    if (keep_count == '0) begin
      keep_eff = HCW'(1);
    end else if (kc_w > CW'(K_MAX)) begin
      keep_eff = HCW'(K_MAX);
    end else begin
      keep_eff = HCW'(kc_w);
    end
  end

  assign cand.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign cand_take  = cand.valid && cand.ready;
  assign idx_inc    = idx + 1'b1;
  assign fill       = held_count < keep_eff;
  assign replace    = dist_sum < max_dist;
  assign out_free   = !out_valid || result.ready;
  assign out_load   = out_free && (state == S_EMIT_LD || state == S_EMPTY);

  always_comb begin
    dctl.op   = DOP_IDLE;
    dctl.last = cur_last;
    unique case (state)
      S_IDLE: begin
        if (cand_take) begin
          if (cand.kind == KIND_FINISH || (cand.skip_cand && cand.last_elem)) begin
            dctl.op = DOP_CLEAR;
          end else if (!cand.skip_cand) begin
            dctl.op = DOP_LOAD;
          end
        end
      end
      S_MUL_W:  dctl.op = DOP_MUL_W;
      S_MUL_SQ: dctl.op = DOP_MUL_SQ;
      S_ACC:    dctl.op = DOP_ACC;
      default:  dctl.op = DOP_IDLE;
    endcase
  end

  // free slots first, then the current maximum
  assign wr_en   = (state == S_ACC) && cur_last && (fill || replace);
  assign wr_addr = fill ? held_count[SAW-1:0] : max_slot;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_ids[wr_addr]   <= cur_id;
      slot_dists[wr_addr] <= dist_sum;
    end
    rd_id   <= slot_ids[idx[SAW-1:0]];
    rd_dist <= slot_dists[idx[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      keep_count <= KEEP_RESET;
      held_count <= '0;
      max_slot   <= '0;
      idx        <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        keep_count <= cfg.keep_count;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cand_take) begin
            cur_id   <= cand.cand_id;
            cur_last <= cand.last_elem;
            if (cand.kind == KIND_FINISH) begin
              max_slot <= '0;
              idx      <= '0;
              state    <= (held_count == '0) ? S_EMPTY : S_EMIT_RD;
            end else if (!cand.skip_cand) begin
              state <= S_MUL_W;
            end
          end
        end
        S_MUL_W:  state <= S_MUL_SQ;
        S_MUL_SQ: state <= S_ACC;
        S_ACC: begin
          if (cur_last && !fill && replace) begin
            idx   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
          if (cur_last && fill) begin
            held_count <= held_count + 1'b1;
            if (held_count == '0 || dist_sum > max_dist) begin
              max_slot <= held_count[SAW-1:0];
              max_dist <= dist_sum;
            end
          end
        end
        S_SCAN: begin
          // read pipelined one slot ahead of the compare
          if (idx < held_count) begin
            idx       <= idx_inc;
            pend      <= 1'b1;
            pend_slot <= idx[SAW-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (pend && (pend_slot == '0 || rd_dist > best_dist)) begin
            best_slot <= pend_slot;
            best_dist <= rd_dist;
          end
          if (idx == held_count && !pend) begin
            max_slot <= best_slot;
            max_dist <= best_dist;
            state    <= S_IDLE;
          end
        end
        S_EMIT_RD: state <= S_EMIT_LD;
        S_EMIT_LD: begin
          if (out_free) begin
            out_id       <= rd_id;
            out_distance <= rd_dist;
            out_last     <= (idx_inc == held_count);
            out_empty    <= 1'b0;
            if (idx_inc == held_count) begin
              held_count <= '0;
              state      <= S_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= S_EMIT_RD;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_id       <= '0;
            out_distance <= '0;
            out_last     <= 1'b1;
            out_empty    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.out_id       = out_id;
  assign result.out_distance = out_distance;
  assign result.out_last     = out_last;
  assign result.out_empty    = out_empty;

`include "whitened_k_nearest_selector_core_assert.svh"

  `WKN_ASSERT_NOW(a_held_bound, 1'b1, held_count <= HCW'(K_MAX))
  `WKN_ASSERT_NOW(a_max_in_set, held_count != '0, max_slot < held_count)
  `WKN_ASSERT_NOW(a_empty_is_last, out_valid && out_empty, out_last)
  `WKN_ASSERT_NEXT(a_finish_busy, cand_take && cand.kind == KIND_FINISH, !cand.ready)

endmodule

// ----- src/wkn_dist_unit.sv -----
// ----------------------------------------------------------------------------
// wkn_dist_unit
// Shared 24x24 multiplier and saturating accumulator for the squared
// whitened distance; sequenced one operation per cycle by the top level.
// ----------------------------------------------------------------------------
module wkn_dist_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  wkn_pkg::dist_ctl_t               ctl,
  input  logic signed [wkn_pkg::DATA_W-1:0] elem_value,
  input  logic signed [wkn_pkg::DATA_W-1:0] ref_mean,
  input  logic [wkn_pkg::DATA_W-1:0]        inv_std,
  output logic [wkn_pkg::DIST_W-1:0]        dist_sum
);
  import wkn_pkg::*;

  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic [DATA_W-1:0]       istd;
  logic [W_W:0]            w_rnd;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic [PROD_W-1:0]       prod;
  logic [DIST_W-1:0]       accum;
  logic [DIST_W:0]         sum;

  assign diff = signed'({elem_value[DATA_W-1], elem_value})
              - signed'({ref_mean[DATA_W-1], ref_mean});

  // Q12.20 product rounded half up to Q12.12
  assign w_rnd = {1'b0, prod[W_W-1:0]} + ROUND_BIAS;

  always_comb begin
    case (ctl.op)
      DOP_MUL_SQ: begin
        mul_a = w_rnd[W_W-1:8];
        mul_b = w_rnd[W_W-1:8];
      end
      default: begin
        mul_a = {{(MUL_W-MAG_W){1'b0}}, mag};
        mul_b = {{(MUL_W-DATA_W){1'b0}}, istd};
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign sum      = {1'b0, accum} + {1'b0, prod[DIST_W-1:0]};
  assign dist_sum = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    case (ctl.op) inside
      DOP_LOAD: begin
        mag  <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        istd <= inv_std;
      end
      DOP_MUL_W, DOP_MUL_SQ: begin
        prod <= mul_p;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
    end else begin
      case (ctl.op)
        DOP_ACC:   accum <= ctl.last ? '0 : dist_sum;
        DOP_CLEAR: accum <= '0;
        default:   ;
      endcase
    end
  end

endmodule

// ----- dv/wkn_selection_checker.sv -----
// ----------------------------------------------------------------------------
// wkn_selection_checker
// Watches the candidate, result and config channels of the whitened k-nearest
// selector, keeps its own copy of the held set and distance accumulator, and
// compares every result transaction with the oldest predicted neighbour.
// ----------------------------------------------------------------------------
module wkn_selection_checker #(
  parameter int K_MAX = 64
) (
  input  logic  clk,
  input  logic  rst,
  wkn_cand_if   cand,
  wkn_result_if result,
  wkn_cfg_if    cfg,
  output int    mismatches,
  output int    awaiting
);
  import wkn_pkg::*;

  localparam logic [63:0] DIST_CEIL = 64'h0000_FFFF_FFFF_FFFF;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
    logic              last_flag;
    logic              empty;
  } neighbour_t;

  neighbour_t        nearest_q[$];
  logic [ID_W-1:0]   slot_id   [K_MAX];
  logic [DIST_W-1:0] slot_dist [K_MAX];
  int                held;
  int                peak_slot;
  logic [DIST_W-1:0] accum;
  logic [KEEP_W-1:0] keep;
  int                fail_count;
  int                queue_depth;

  assign mismatches = fail_count;
  assign awaiting   = queue_depth;

  // |elem - mean| * inv_std rounded to Q12.12, then squared (Q24.24)
  function automatic logic [63:0] whitened_square(logic signed [DATA_W-1:0] x,
                                                  logic signed [DATA_W-1:0] mu,
                                                  logic [DATA_W-1:0] scale);
    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic [63:0]             w;
    logic [63:0]             wr;
    diff = x - mu;
    mag  = diff[MAG_W-1] ? -diff : diff;
    w    = 64'(mag) * 64'(scale);
    wr   = (w + 64'd128) >> 8;
    return wr * wr;
  endfunction

  function automatic void keep_if_nearer(logic [ID_W-1:0] id, logic [DIST_W-1:0] d);
    int k;
    k = (keep == '0) ? 1 : ((int'(keep) > K_MAX) ? K_MAX : int'(keep));
    if (held < k) begin
      slot_id[held]   = id;
      slot_dist[held] = d;
      if (held == 0 || d > slot_dist[peak_slot]) peak_slot = held;
      held++;
    end else if (held > 0 && d < slot_dist[peak_slot]) begin
      slot_id[peak_slot]   = id;
      slot_dist[peak_slot] = d;
      // lowest slot wins on ties
      peak_slot = 0;
      for (int s = 1; s < held; s++) begin
        if (slot_dist[s] > slot_dist[peak_slot]) peak_slot = s;
      end
    end
  endfunction

  function automatic void emit_nearest_set();
    neighbour_t n;
    if (held == 0) begin
      n = '{id: '0, distance: '0, last_flag: 1'b1, empty: 1'b1};
      nearest_q = {nearest_q, n};
    end
    for (int s = 0; s < held; s++) begin
      n = '{id: slot_id[s], distance: slot_dist[s], last_flag: (s == held - 1),
            empty: 1'b0};
      nearest_q = {nearest_q, n};
    end
    held      = 0;
    peak_slot = 0;
    accum     = '0;
  endfunction

  always @(posedge clk) begin
    neighbour_t  want;
    logic [63:0] total;
    if (rst) begin
      held      = 0;
      peak_slot = 0;
      accum     = '0;
      keep      = KEEP_RESET;
      nearest_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) keep = cfg.keep_count;

      if (cand.valid && cand.ready) begin
        if (cand.kind == KIND_FINISH) begin
          emit_nearest_set();
        end else begin
          if (!cand.skip_cand) begin
            total = 64'(accum)
                  + whitened_square(cand.elem_value, cand.ref_mean, cand.inv_std);
            accum = (total > DIST_CEIL) ? DIST_CEIL[DIST_W-1:0] : total[DIST_W-1:0];
            if (cand.last_elem) keep_if_nearer(cand.cand_id, accum);
          end
          if (cand.last_elem) accum = '0;
        end
      end

      if (result.valid && result.ready) begin
        if (nearest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected result transaction: id %h distance %h last %b empty %b",
                     result.out_id, result.out_distance, result.out_last, result.out_empty);
        end else begin
          want = nearest_q.pop_front();
          if (result.out_id !== want.id || result.out_distance !== want.distance ||
              result.out_last !== want.last_flag || result.out_empty !== want.empty) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("result mismatch: expected id %h distance %h last %b empty %b,%s",
                       want.id, want.distance, want.last_flag, want.empty,
                       $sformatf(" got id %h distance %h last %b empty %b",
                                 result.out_id, result.out_distance,
                                 result.out_last, result.out_empty));
          end
        end
      end
    end
    queue_depth = nearest_q.size();
  end

endmodule

// ----- dv/tb_whitened_k_nearest_selector_core.sv -----
// ----------------------------------------------------------------------------
// tb_whitened_k_nearest_selector_core
// Drives candidate elements, finish transactions and keep_count writes into
// the selector with random gaps and result back-pressure; the checker beside
// the block predicts the emitted nearest sets and counts mismatches.
// ----------------------------------------------------------------------------
module tb_whitened_k_nearest_selector_core;
  import wkn_pkg::*;

  localparam int K_MAX          = 64;
  localparam int SETTLE_CYCLES  = K_MAX + 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {VAL_WIDE, VAL_TIES, VAL_EDGE} value_mix_t;

  localparam logic [DATA_W-1:0] EDGE_VALS   [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
  localparam logic [DATA_W-1:0] EDGE_SCALES [4] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h1000};

  logic clk;
  logic rst;
  logic res_ready = 1'b0;
  bit   fast_mode;
  int   mismatches;
  int   awaiting;
  int   idle_cycles;
  int   res_stall;

  wkn_cand_if   cand_ch ();
  wkn_result_if res_ch ();
  wkn_cfg_if    cfg_ch ();

  assign res_ch.ready = res_ready;

  whitened_k_nearest_selector_core #(.K_MAX(K_MAX)) u_top (
    .clk    (clk),
    .rst    (rst),
    .cand   (cand_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  wkn_selection_checker #(.K_MAX(K_MAX)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cand       (cand_ch),
    .result     (res_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result back-pressure: a drawn stall after each transaction, and now and
  // then a stall raised while idle so first results of a set get held too
  always @(posedge clk) begin
    int n;
    if (rst) begin
      res_ready <= 1'b0;
      res_stall <= 0;
    end else if (res_ch.valid && res_ready) begin
      n = fast_mode ? 0 : $urandom_range(0, 4);
      res_stall <= n;
      res_ready <= (n == 0);
    end else if (!res_ready) begin
      if (res_stall > 1) begin
        res_stall <= res_stall - 1;
      end else begin
        res_stall <= 0;
        res_ready <= 1'b1;
      end
    end else if (!res_ch.valid && !fast_mode && $urandom_range(0, 3) == 0) begin
      res_stall <= $urandom_range(1, 4);
      res_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic kind, input logic [ID_W-1:0] id,
                           input logic [DATA_W-1:0] elem, input logic [DATA_W-1:0] mean,
                           input logic [DATA_W-1:0] inv, input logic last, input logic skip);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cand_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand_ch.valid      <= 1'b1;
    cand_ch.kind       <= kind;
    cand_ch.cand_id    <= id;
    cand_ch.elem_value <= elem;
    cand_ch.ref_mean   <= mean;
    cand_ch.inv_std    <= inv;
    cand_ch.last_elem  <= last;
    cand_ch.skip_cand  <= skip;
    @(posedge clk);
    while (!cand_ch.ready) @(posedge clk);
  endtask

  // payload of a finish is don't-care, so it carries noise
  task automatic send_finish();
    send_item(KIND_FINISH, ID_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
              DATA_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic send_candidate(input logic [ID_W-1:0] id, input int dim, input logic skip,
                                input value_mix_t mix);
    logic [DATA_W-1:0] elem;
    logic [DATA_W-1:0] mean;
    logic [DATA_W-1:0] inv;
    for (int i = 0; i < dim; i++) begin
      case (mix)
        VAL_TIES: begin
          elem = DATA_W'($urandom_range(0, 3));
          mean = '0;
          inv  = 16'h1000;
        end
        VAL_EDGE: begin
          elem = EDGE_VALS[$urandom_range(0, 3)];
          mean = EDGE_VALS[$urandom_range(0, 3)];
          inv  = EDGE_SCALES[$urandom_range(0, 3)];
        end
        default: begin
          elem = DATA_W'($urandom);
          mean = DATA_W'($urandom);
          inv  = DATA_W'($urandom);
        end
      endcase
      send_item(KIND_ELEM, id, elem, mean, inv, (i == dim - 1), skip);
    end
  endtask

  // finish_one_in of 0 means no finish inside the phase and no abandoned vectors
  task automatic random_phase(input int n_cands, input int max_dim, input int finish_one_in,
                              input bit close_set);
    logic [ID_W-1:0] id;
    int              dim;
    value_mix_t      mix;
    id = ID_W'($urandom);
    for (int c = 0; c < n_cands; c++) begin
      if ($urandom_range(0, 15) == 0) fast_mode = !fast_mode;
      if ($urandom_range(0, 4) != 0) id = ID_W'($urandom);
      dim = $urandom_range(1, max_dim);
      if (max_dim > 1 && $urandom_range(0, 9) == 0) dim = $urandom_range(4, 10);
      case ($urandom_range(0, 5))
        0:       mix = VAL_TIES;
        1:       mix = VAL_EDGE;
        default: mix = VAL_WIDE;
      endcase
      if (finish_one_in > 0 && $urandom_range(0, 24) == 0) begin
        // vector abandoned part-way by a finish
        send_item(KIND_ELEM, id, DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                  1'b0, 1'b0);
        send_finish();
      end else begin
        send_candidate(id, dim, ($urandom_range(0, 7) == 0), mix);
      end
      if (finish_one_in > 0 && $urandom_range(1, finish_one_in) == 1) send_finish();
    end
    if (close_set) send_finish();
  endtask

  // wait for every predicted result, then for any rescan still running
  task automatic drain();
    cand_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] value);
    drain();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.keep_count <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst                <= 1'b1;
    cand_ch.valid      <= 1'b0;
    cand_ch.kind       <= KIND_ELEM;
    cand_ch.cand_id    <= '0;
    cand_ch.elem_value <= '0;
    cand_ch.ref_mean   <= '0;
    cand_ch.inv_std    <= '0;
    cand_ch.last_elem  <= 1'b0;
    cand_ch.skip_cand  <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.keep_count  <= KEEP_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part, default keep count of 8
    send_finish();
    send_item(KIND_ELEM, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 1'b0);
    // two maximal terms saturate the accumulator
    send_item(KIND_ELEM, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0);
    send_item(KIND_ELEM, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0);
    send_item(KIND_ELEM, 16'h1234, 16'h1234, 16'h1234, 16'hFFFF, 1'b1, 1'b0);
    // exactly half an LSB rounds up, just under rounds down
    send_item(KIND_ELEM, 16'h0101, 16'h0001, 16'h0000, 16'h0080, 1'b1, 1'b0);
    send_item(KIND_ELEM, 16'h0102, 16'h0000, 16'h0001, 16'h007F, 1'b1, 1'b0);
    send_item(KIND_ELEM, 16'h0200, 16'h4000, 16'hC000, 16'h0000, 1'b1, 1'b0);
    // skipped candidate must leave nothing behind
    send_item(KIND_ELEM, 16'h0300, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 1'b1);
    send_item(KIND_ELEM, 16'h0300, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 1'b1);
    send_item(KIND_ELEM, 16'h0005, 16'h0100, 16'h0000, 16'h1000, 1'b1, 1'b0);
    send_item(KIND_ELEM, 16'h0005, 16'hFF00, 16'h0100, 16'h1000, 1'b1, 1'b0);
    // set now full: first displaces the saturated entry, second ties the max
    send_item(KIND_ELEM, 16'h0400, 16'h0000, 16'h0080, 16'h2000, 1'b1, 1'b0);
    send_item(KIND_ELEM, 16'h0401, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 1'b0);
    send_item(KIND_ELEM, 16'h0500, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 1'b0);
    send_finish();
    send_item(KIND_ELEM, 16'h0501, 16'h0100, 16'h0000, 16'h1000, 1'b1, 1'b0);
    send_finish();

    write_keep(7'd1);
    random_phase(10, 3, 4, 1'b1);
    // above the slot count: clamps, more offers than slots
    write_keep(7'd127);
    random_phase(66, 1, 0, 1'b1);
    write_keep(7'd64);
    random_phase(10, 3, 6, 1'b1);
    write_keep(7'd0);
    random_phase(10, 3, 4, 1'b1);
    // keep count lowered under a larger held set
    write_keep(7'd6);
    random_phase(10, 2, 0, 1'b0);
    write_keep(7'd2);
    random_phase(8, 2, 0, 1'b1);
    write_keep(KEEP_W'($urandom_range(3, 12)));
    random_phase(8, 3, 5, 1'b1);

    drain();
    if (mismatches == 0 && awaiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/wkn_pkg.sv
src/wkn_channels.sv
src/wkn_dist_unit.sv
src/whitened_k_nearest_selector_core.sv
dv/wkn_selection_checker.sv
dv/tb_whitened_k_nearest_selector_core.sv
